// File: rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int POS_W  = 11;
  localparam int CELL_W = 16;

  // opcodes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // character codes with a cursor meaning, and the printable range
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FIRST = 8'h20;
  localparam logic [7:0] CH_LAST  = 8'h7F;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [7:0]       char_code;
    logic [3:0]       bg_color;
    logic [3:0]       fg_color;
    logic [POS_W-1:0] cell_index;
  } tcw_req_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_data;
  } tcw_rsp_t;

  typedef struct packed {
    logic load_item;
    logic put_step;
    logic home;
    logic read_issue;
    logic sweep_en;
    logic sweep_copy;
    logic out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic       need_scroll;
    logic       sweep_last;
    logic       out_free;
    logic [1:0] opcode;
  } tcw_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/tcw_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_dp import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire tcw_req_t req,
  input  wire tcw_cmd_t cmd,
  output tcw_stat_t     stat,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output tcw_rsp_t      rsp
);

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
  localparam int AW         = $clog2(CELLS);
  localparam int PW         = (AW > POS_W) ? AW : POS_W;
  localparam int CW         = $clog2(COLUMNS);
  localparam int RW         = $clog2(ROWS);

  // frame store
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data;

  // latched item
  logic [1:0]       op;
  logic [7:0]       chr;
  logic [7:0]       attr;
  logic [POS_W-1:0] index;

  // cursor
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW:0]   col_next;
  logic [RW:0]   row_next;
  logic          printable;

  // sweep
  logic [AW-1:0] cnt;
  logic          wr_pend;
  logic          wr_copy;
  logic [AW-1:0] wr_addr;
  logic          copy_rd;

  logic [PW-1:0] curs_lin;
  logic [PW-1:0] index_ext;
  logic          read_ok;

  logic              we;
  logic [AW-1:0]     wa;
  logic [CELL_W-1:0] wd;
  logic              re;
  logic [AW-1:0]     ra;

  assign curs_lin  = PW'(row) * PW'(COLUMNS) + PW'(col);
  assign index_ext = PW'(index);
  assign read_ok   = (op == OP_READ) && (index_ext < PW'(CELLS));
  assign printable = (chr >= CH_FIRST) && (chr <= CH_LAST);

  // cursor movement for one put
  always_comb begin
    col_next = {1'b0, col};
    row_next = {1'b0, row};
    case (chr)
      CH_BS: begin
        if (col != '0) col_next = {1'b0, col} - (CW+1)'(1);
      end
      CH_TAB: begin
        col_next = ({1'b0, col} + (CW+1)'(8)) & ~((CW+1)'(7));
      end
      CH_CR: begin
        col_next = '0;
      end
      CH_LF: begin
        col_next = '0;
        row_next = {1'b0, row} + (RW+1)'(1);
      end
      default: begin
        if (printable) col_next = {1'b0, col} + (CW+1)'(1);
      end
    endcase
    if (col_next >= (CW+1)'(COLUMNS)) begin
      col_next = '0;
      row_next = row_next + (RW+1)'(1);
    end
  end

  assign stat.need_scroll = (row_next >= (RW+1)'(ROWS));
  assign stat.sweep_last  = (cnt == AW'(CELLS - 1));
  assign stat.out_free    = !rsp_valid || rsp_ready;
  assign stat.opcode      = op;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op    <= req.opcode;
      chr   <= req.char_code;
      attr  <= {req.bg_color, req.fg_color};
      index <= req.cell_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.home) begin
      col <= '0;
      row <= '0;
    end else if (cmd.put_step) begin
      col <= col_next[CW-1:0];
      row <= stat.need_scroll ? RW'(ROWS - 1) : row_next[RW-1:0];
    end
  end

  assign copy_rd = cmd.sweep_copy && (cnt < AW'(COPY_CELLS));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.sweep_en;
      if (cmd.sweep_en) cnt <= stat.sweep_last ? '0 : cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= cnt;
    wr_copy <= copy_rd;
  end

  // one write port: delayed sweep write or a put write, never both
  always_comb begin
    we = wr_pend || (cmd.put_step && printable);
    wa = wr_pend ? wr_addr : curs_lin[AW-1:0];
    if (wr_pend) wd = wr_copy ? rd_data : BLANK_CELL;
    else         wd = {attr, chr};
    re = copy_rd || cmd.read_issue;
    ra = copy_rd ? (cnt + AW'(COLUMNS)) : index_ext[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (re) rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.cursor_pos <= curs_lin[POS_W-1:0];
      rsp.cell_data  <= read_ok ? rd_data : '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire tcw_stat_t stat,
  output tcw_cmd_t       cmd
);

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_EXEC   = 6'b000100,
    ST_SCROLL = 6'b001000,
    ST_CLEAR  = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_INIT: begin
        cmd.sweep_en = 1'b1;
        if (stat.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.load_item = req_valid;
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (stat.opcode)
          OP_PUT: begin
            cmd.put_step = 1'b1;
            state_next   = stat.need_scroll ? ST_SCROLL : ST_EMIT;
          end
          OP_CLEAR: begin
            cmd.home   = 1'b1;
            state_next = ST_CLEAR;
          end
          OP_READ: begin
            cmd.read_issue = 1'b1;
            state_next     = ST_EMIT;
          end
          default: begin
            state_next = ST_EMIT;
          end
        endcase
      end
      ST_SCROLL: begin
        cmd.sweep_en   = 1'b1;
        cmd.sweep_copy = 1'b1;
        if (stat.sweep_last) state_next = ST_EMIT;
      end
      ST_CLEAR: begin
        cmd.sweep_en = 1'b1;
        if (stat.sweep_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.out_load = stat.out_free;
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else     state <= state_next;
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == ST_EXEC)
    else $error("accepted item did not start execution");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over an untaken result");

  a_init_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_INIT && stat.sweep_last |=> state == ST_IDLE)
    else $error("reset clearing pass did not end in idle");

  a_scroll_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCROLL && stat.sweep_last |=> state == ST_EMIT)
    else $error("scroll did not end in result");

endmodule

`default_nettype wire

// File: rtl/core/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// text-mode console writer: a COLUMNS x ROWS frame store of 16-bit cells (attribute in the
// high byte, character in the low byte) and a cursor. a put item either moves the cursor
// (backspace, tab, carriage return, line feed) or stores a printable byte 0x20..0x7f with
// attribute {bg_color, fg_color} and advances; the cursor wraps at the right edge and
// the screen scrolls at the bottom. a clear item blanks every cell to 0x0f20 and homes the
// cursor; a read item returns one cell (0 beyond the store). every item gives one result
// carrying the linear cursor position. timing is set by the single-port-write frame store:
// put, read and unused opcodes pass from accept through the execute and result states; a
// clear writes one cell a cycle over the whole store; a put that scrolls adds a sweep over
// the store, copying one cell a cycle and then blanking the last row. after reset the store
// is cleared by the same sweep, during which no item is accepted. a finished result sits in
// an output register, so the next item may be accepted while it waits to be taken.

module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic     clk,
  input  wire logic     rst,
  // item channel
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire tcw_req_t req,
  // result channel
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output tcw_rsp_t      rsp
);

  // controller to datapath commands and back
  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  // sequencer: reset sweep, item dispatch, scroll/clear sweeps, result hand-off
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // frame store, cursor, sweep counter and result register
  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// File: tb/text_console_writer_test.sv
`timescale 1ns / 1ps

module text_console_writer_test;
  import tcw_pkg::*;

  // screen geometry of the default build
  localparam int COLS  = 80;
  localparam int LINES = 25;
  localparam int CELLS = COLS * LINES;

  // opcode 3 has no meaning, the block must leave everything alone
  localparam logic [1:0] OP_SPARE = 2'd3;

  // random part: four idling phases of equal size
  localparam int RANDOM_ITEMS = 290;
  localparam int PHASES       = 4;
  localparam int REPORT_MAX   = 10;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  tcw_req_t req       = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  tcw_rsp_t rsp;

  text_console_writer dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  // one row of the directed table; want is only used where typed is set
  typedef struct {
    tcw_req_t item;
    bit       typed;
    tcw_rsp_t want;
  } stim_row_t;

  stim_row_t directed_rows[$];

  // shadow copy of the console: frame store and cursor
  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;

  // cursor/cell results still owed by the block, oldest first
  tcw_rsp_t    cursor_cell_fifo[$];
  tcw_rsp_t    head_rsp;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;

  // receiver stall control: the enable is driven from the stimulus thread, the hold by the receiver
  bit          rsp_stalls = 1'b0;
  int unsigned rsp_hold   = 0;

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = BLANK_CELL;
  endfunction

  // apply one item to the shadow console and return the result it yields
  function automatic tcw_rsp_t console_update(tcw_req_t r);
    tcw_rsp_t    res;
    int unsigned addr;
    res = '0;
    case (r.opcode)
      OP_PUT: begin
        if (r.char_code == CH_BS) begin
          if (cur_col != 0) cur_col--;
        end else if (r.char_code == CH_TAB) begin
          cur_col = (cur_col + 8) & ~32'd7;
        end else if (r.char_code == CH_CR) begin
          cur_col = 0;
        end else if (r.char_code == CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (r.char_code >= CH_FIRST && r.char_code <= CH_LAST) begin
          addr = cur_row * COLS + cur_col;
          if (addr < CELLS) screen[addr] = {r.bg_color, r.fg_color, r.char_code};
          cur_col++;
        end
        // wrap at the right edge, scroll at the bottom
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= LINES) begin
          for (int i = 0; i < (LINES - 1) * COLS; i++) screen[i] = screen[i + COLS];
          for (int i = (LINES - 1) * COLS; i < CELLS; i++) screen[i] = BLANK_CELL;
          cur_row = LINES - 1;
        end
      end
      OP_CLEAR: begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;
      end
      OP_READ: begin
        if (r.cell_index < CELLS) res.cell_data = screen[r.cell_index];
      end
      default: ;
    endcase
    res.cursor_pos = POS_W'(cur_row * COLS + cur_col);
    return res;
  endfunction

  function automatic void add_row(logic [1:0] op, logic [7:0] ch, logic [3:0] bg,
                                  logic [3:0] fg, logic [POS_W-1:0] idx, bit typed,
                                  logic [POS_W-1:0] pos, logic [CELL_W-1:0] data);
    stim_row_t row;
    row.item  = '{opcode: op, char_code: ch, bg_color: bg, fg_color: fg,
                  cell_index: idx};
    row.typed = typed;
    row.want  = '{cursor_pos: pos, cell_data: data};
    directed_rows.push_back(row);
  endfunction

  // mostly short gaps, some medium, a few long
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 2);
    if (roll < 95) return $urandom_range(3, 12);
    return $urandom_range(20, 90);
  endfunction

  // console traffic: mostly text with line feeds so the screen fills and scrolls,
  // reads near the cursor, anywhere and past the store, rare clears, some junk bytes and spare opcodes
  function automatic tcw_req_t random_item();
    tcw_req_t    r;
    int unsigned roll;
    int unsigned pos;
    r.opcode     = OP_PUT;
    r.char_code  = 8'($urandom_range(0, 255));
    r.bg_color   = 4'($urandom_range(0, 15));
    r.fg_color   = 4'($urandom_range(0, 15));
    r.cell_index = POS_W'($urandom_range(0, 2047));
    roll = $urandom_range(0, 999);
    if (roll < 5) begin
      r.opcode = OP_CLEAR;
    end else if (roll < 25) begin
      r.opcode = OP_SPARE;
    end else if (roll < 215) begin
      r.opcode = OP_READ;
      roll = $urandom_range(0, 99);
      pos  = cur_row * COLS + cur_col;
      if (roll < 45)
        r.cell_index = POS_W'(pos - $urandom_range(0, (pos < 2 * COLS) ? pos : 2 * COLS));
      else if (roll < 85)
        r.cell_index = POS_W'($urandom_range(0, CELLS - 1));
      else
        r.cell_index = POS_W'($urandom_range(CELLS, 2047));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 50)      r.char_code = 8'($urandom_range(CH_FIRST, CH_LAST));
      else if (roll < 70) r.char_code = CH_LF;
      else if (roll < 78) r.char_code = CH_TAB;
      else if (roll < 84) r.char_code = CH_BS;
      else if (roll < 88) r.char_code = CH_CR;
      else if (roll < 94) r.char_code = 8'($urandom_range(0, 31));
      else                r.char_code = 8'($urandom_range(128, 255));
    end
    return r;
  endfunction

  function automatic void flag_mismatch(string msg);
    if (mismatches < REPORT_MAX) $display("mismatch: %s", msg);
    mismatches++;
  endfunction

  // offer one item after the given idle gap, hold it until taken, then log what it owes
  task automatic send_item(tcw_req_t item, bit typed, tcw_rsp_t want, int unsigned gap);
    tcw_rsp_t guess;
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    guess = console_update(item);
    cursor_cell_fifo.push_back(typed ? want : guess);
  endtask

  // drop valid and wait until every owed result has come back
  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (cursor_cell_fifo.size() != 0) @(posedge clk);
  endtask

  // receiver: ready changes at the falling edge, stalls only while enabled
  always @(negedge clk) begin
    if (rsp_hold != 0) begin
      rsp_ready <= 1'b0;
      rsp_hold  <= rsp_hold - 1;
    end else begin
      rsp_ready <= 1'b1;
      if (rsp_stalls && $urandom_range(0, 3) == 0) rsp_hold <= idle_len();
    end
  end

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      results_seen++;
      if (cursor_cell_fifo.size() == 0) begin
        flag_mismatch($sformatf("result %0d not owed: cursor_pos %0d cell_data %h",
                                results_seen, rsp.cursor_pos, rsp.cell_data));
      end else begin
        head_rsp = cursor_cell_fifo.pop_front();
        if (rsp.cursor_pos !== head_rsp.cursor_pos || rsp.cell_data !== head_rsp.cell_data)
          flag_mismatch($sformatf(
            "result %0d: cursor_pos exp %0d got %0d, cell_data exp %h got %h",
            results_seen, head_rsp.cursor_pos, rsp.cursor_pos,
            head_rsp.cell_data, rsp.cell_data));
      end
    end
  end

  initial begin
    int unsigned gap;
    bit          sender_gaps;

    blank_screen();
    cur_col = 0;
    cur_row = 0;

    // reads right after reset see the blank screen
    add_row(OP_READ,  8'h00,    4'h0, 4'h0, 11'd0,    1, 11'd0,  BLANK_CELL);
    add_row(OP_READ,  8'h00,    4'h0, 4'h0, 11'd1999, 1, 11'd0,  BLANK_CELL);
    // first index past the store reads as zero
    add_row(OP_READ,  8'h00,    4'h0, 4'h0, 11'd2000, 1, 11'd0,  16'h0000);
    // backspace at column zero does nothing
    add_row(OP_PUT,   CH_BS,    4'h0, 4'h0, 11'd0,    1, 11'd0,  16'h0000);
    // a printable byte and both printable extremes, with extreme colors
    add_row(OP_PUT,   8'h41,    4'hF, 4'h0, 11'd0,    1, 11'd1,  16'h0000);
    add_row(OP_PUT,   CH_FIRST, 4'h0, 4'hF, 11'd0,    1, 11'd2,  16'h0000);
    add_row(OP_PUT,   CH_LAST,  4'hF, 4'hF, 11'd0,    1, 11'd3,  16'h0000);
    add_row(OP_READ,  8'h00,    4'h0, 4'h0, 11'd0,    1, 11'd3,  16'hF041);
    add_row(OP_READ,  8'h00,    4'h0, 4'h0, 11'd2,    1, 11'd3,  16'hFF7F);
    // non-printing bytes below and above the printable range are ignored
    add_row(OP_PUT,   8'h1F,    4'h3, 4'h5, 11'd0,    1, 11'd3,  16'h0000);
    add_row(OP_PUT,   8'h80,    4'h3, 4'h5, 11'd0,    1, 11'd3,  16'h0000);
    add_row(OP_PUT,   CH_CR,    4'h0, 4'h0, 11'd0,    1, 11'd0,  16'h0000);
    add_row(OP_PUT,   CH_LF,    4'h0, 4'h0, 11'd0,    1, 11'd80, 16'h0000);
    // spare opcode with every other bit set changes nothing
    add_row(OP_SPARE, 8'hFF,    4'hF, 4'hF, 11'h7FF,  1, 11'd80, 16'h0000);
    // ten tabs run past the right edge and wrap to the next row
    repeat (10) add_row(OP_PUT, CH_TAB, 4'h0, 4'h0, 11'h555, 0, 11'd0, 16'h0000);
    // clear homes the cursor
    add_row(OP_CLEAR, 8'h00,    4'h0, 4'h0, 11'd0,    1, 11'd0,  16'h0000);

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want, 0);
    settle();

    // phases: no idling, both sides idle, sender only, receiver only;
    // between phases the sender holds off until the block has drained
    for (int phase = 0; phase < PHASES; phase++) begin
      rsp_stalls  = (phase == 1 || phase == 3);
      sender_gaps = (phase == 1 || phase == 2);
      repeat (RANDOM_ITEMS / PHASES) begin
        gap = 0;
        if (sender_gaps && $urandom_range(0, 1) == 1) gap = idle_len();
        send_item(random_item(), 1'b0, '0, gap);
      end
      settle();
    end

    // a few more cycles to catch any stray result
    repeat (10) @(posedge clk);
    if (mismatches == 0 && cursor_cell_fifo.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, well beyond a run where every put scrolls and every side stalls long
  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_dp.sv
rtl/core/tcw_ctrl.sv
rtl/core/text_console_writer.sv
tb/text_console_writer_test.sv
